@@ rtl/bresenham_line_pixel_generator_defines.svh @@
// ----------------------------------------------------------------------------
// bresenham line pixel generator: shared assertion macros
// same-cycle implication and next-cycle forms, clocked on clk, off in reset
// ----------------------------------------------------------------------------
`ifndef BRESENHAM_LINE_PIXEL_GENERATOR_DEFINES_SVH
`define BRESENHAM_LINE_PIXEL_GENERATOR_DEFINES_SVH

// same-cycle implication
`define BLPG_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BLPG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/blpg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blpg_pkg
// types and constants shared by the line pixel generator modules
// ----------------------------------------------------------------------------
package blpg_pkg;

    localparam int COORD_W  = 5;
    localparam int SIZE_W   = 6;
    localparam int VALUE_W  = 8;
    localparam int SPAN_W   = 6;
    localparam int SPANN_W  = 7;
    localparam int ERR_W    = 8;

    // depth of the command queue between front and walker
    localparam int CMD_DEPTH = 2;
    localparam int CMD_PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

    // register map: index is paddr[2]
    localparam logic REG_CANVAS_WIDTH  = 1'b0;
    localparam logic REG_CANVAS_HEIGHT = 1'b1;

    localparam logic [SIZE_W-1:0] CANVAS_SIZE_RESET = 6'd32;

    // classified line command, ready for the walker
    typedef struct packed {
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
        logic [SPAN_W-1:0]  span_x;      // |end_x - start_x|
        logic [SPANN_W-1:0] span_y_neg;  // -|end_y - start_y|, two's complement
        logic [1:0]         step_dirs;   // bit 0: x steps down, bit 1: y steps down
        logic [VALUE_W-1:0] value;
    } line_cmd_t;

endpackage

@@ rtl/bresenham_line_pixel_generator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bresenham_line_pixel_generator
// line commands in, pixel write transactions out, along the line in order,
// with the final pixel of each line flagged
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  command   in         push / full            start_x start_y end_x end_y pixel_value
//  pixel     out        empty / pop            pixel_col pixel_row write_value last_pixel
//  config    in         apb psel/penable       canvas_width (0x0) canvas_height (0x4)
//
//  the walker loads each line, then makes one pixel per cycle while its
//  output register is free, ending with the flagged last pixel
//  a command is registered in the command queue, then the walk state, then the output register
//  commands off the canvas are consumed with no pixel transactions
//  the two-entry command queue lets commands be taken while a line is walked
//  rst_n clears control state asynchronously; no clearing pass is needed
// ----------------------------------------------------------------------------
module bresenham_line_pixel_generator
    import blpg_pkg::*;
#(
    parameter int CANVAS_MAX = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    // command queue side
    input  logic               push,
    output logic               full,
    input  logic [COORD_W-1:0] start_x,
    input  logic [COORD_W-1:0] start_y,
    input  logic [COORD_W-1:0] end_x,
    input  logic [COORD_W-1:0] end_y,
    input  logic [VALUE_W-1:0] pixel_value,
    // pixel queue side
    output logic               empty,
    input  logic               pop,
    output logic [COORD_W-1:0] pixel_col,
    output logic [COORD_W-1:0] pixel_row,
    output logic [VALUE_W-1:0] write_value,
    output logic               last_pixel,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [SIZE_W-1:0] canvas_width_reg;
    logic [SIZE_W-1:0] canvas_height_reg;
    logic              cfg_write;
    logic              cmd_write;
    line_cmd_t         cmd_in;
    line_cmd_t         cmd_out;
    logic              fifo_empty;
    logic              fifo_pop;

    // configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            canvas_width_reg  <= CANVAS_SIZE_RESET;
            canvas_height_reg <= CANVAS_SIZE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_CANVAS_WIDTH:  canvas_width_reg  <= pwdata[SIZE_W-1:0];
                REG_CANVAS_HEIGHT: canvas_height_reg <= pwdata[SIZE_W-1:0];
                default:           canvas_width_reg  <= canvas_width_reg;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        unique case (paddr[2])
            REG_CANVAS_WIDTH:  prdata = {{(32-SIZE_W){1'b0}}, canvas_width_reg};
            REG_CANVAS_HEIGHT: prdata = {{(32-SIZE_W){1'b0}}, canvas_height_reg};
            default:           prdata = '0;
        endcase
    end

    // front: accept and classify
    blpg_front #(
        .CANVAS_MAX (CANVAS_MAX)
    ) u_front (
        .push          (push),
        .queue_full    (full),
        .start_x       (start_x),
        .start_y       (start_y),
        .end_x         (end_x),
        .end_y         (end_y),
        .pixel_value   (pixel_value),
        .canvas_width  (canvas_width_reg),
        .canvas_height (canvas_height_reg),
        .cmd_write     (cmd_write),
        .cmd           (cmd_in)
    );

    // command queue
    blpg_cmd_fifo u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_write),
        .wr_data (cmd_in),
        .rd_en   (fifo_pop),
        .rd_data (cmd_out),
        .full    (full),
        .empty   (fifo_empty)
    );

    // back: line walk and result register
    blpg_walker u_walker (
        .clk         (clk),
        .rst_n       (rst_n),
        .fifo_cmd    (cmd_out),
        .fifo_empty  (fifo_empty),
        .fifo_pop    (fifo_pop),
        .pop         (pop),
        .empty       (empty),
        .pixel_col   (pixel_col),
        .pixel_row   (pixel_row),
        .write_value (write_value),
        .last_pixel  (last_pixel)
    );

endmodule

@@ rtl/blpg_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blpg_front
// accepts line commands, drops those off the canvas, works out spans and
// step directions for the walker
// ----------------------------------------------------------------------------
module blpg_front
    import blpg_pkg::*;
#(
    parameter int CANVAS_MAX = 32
)
(
    input  logic               push,
    input  logic               queue_full,
    input  logic [COORD_W-1:0] start_x,
    input  logic [COORD_W-1:0] start_y,
    input  logic [COORD_W-1:0] end_x,
    input  logic [COORD_W-1:0] end_y,
    input  logic [VALUE_W-1:0] pixel_value,
    input  logic [SIZE_W-1:0]  canvas_width,
    input  logic [SIZE_W-1:0]  canvas_height,
    output logic               cmd_write,
    output line_cmd_t          cmd
);

    localparam logic [SIZE_W:0] MAX_SIZE = (SIZE_W+1)'(CANVAS_MAX);

    logic [SIZE_W:0]    eff_w;
    logic [SIZE_W:0]    eff_h;
    logic               in_bounds;
    logic [COORD_W-1:0] abs_x;
    logic [COORD_W-1:0] abs_y;

    // size registers above the build limit act as the limit
    always_comb
    begin
        eff_w = ({1'b0, canvas_width} > MAX_SIZE) ? MAX_SIZE : {1'b0, canvas_width};
        eff_h = ({1'b0, canvas_height} > MAX_SIZE) ? MAX_SIZE : {1'b0, canvas_height};
    end

    // every endpoint coordinate must be below its size
    assign in_bounds = ({2'b00, start_x} < eff_w) && ({2'b00, end_x} < eff_w) &&
                       ({2'b00, start_y} < eff_h) && ({2'b00, end_y} < eff_h);

    // spans and directions
    always_comb
    begin
        abs_x = (end_x > start_x) ? (end_x - start_x) : (start_x - end_x);
        abs_y = (end_y > start_y) ? (end_y - start_y) : (start_y - end_y);
        cmd.start_x      = start_x;
        cmd.start_y      = start_y;
        cmd.end_x        = end_x;
        cmd.end_y        = end_y;
        cmd.span_x       = {1'b0, abs_x};
        cmd.span_y_neg   = SPANN_W'(0) - {2'b00, abs_y};
        cmd.step_dirs[0] = !(start_x < end_x);
        cmd.step_dirs[1] = !(start_y < end_y);
        cmd.value        = pixel_value;
    end

    // rejected transactions are consumed without reaching the queue
    assign cmd_write = push && !queue_full && in_bounds;

endmodule

@@ rtl/blpg_cmd_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blpg_cmd_fifo
// short queue of classified commands between front and walker
// ----------------------------------------------------------------------------
module blpg_cmd_fifo
    import blpg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_en,
    input  line_cmd_t wr_data,
    input  logic      rd_en,
    output line_cmd_t rd_data,
    output logic      full,
    output logic      empty
);

    line_cmd_t              entry_reg [CMD_DEPTH];
    logic [CMD_PTR_W-1:0]   wr_ptr_reg;
    logic [CMD_PTR_W-1:0]   wr_ptr_next;
    logic [CMD_PTR_W-1:0]   rd_ptr_reg;
    logic [CMD_PTR_W-1:0]   rd_ptr_next;
    logic [CMD_CNT_W-1:0]   cnt_reg;
    logic [CMD_CNT_W-1:0]   cnt_next;
    logic                   do_wr;
    logic                   do_rd;

    assign full    = (cnt_reg == CMD_CNT_W'(CMD_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_data = entry_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ rtl/blpg_walker.sv @@
`timescale 1ns / 1ps
`include "bresenham_line_pixel_generator_defines.svh"
// ----------------------------------------------------------------------------
// blpg_walker
// takes one command at a time from the queue and walks the line with the
// error-term method, one pixel per cycle while the output register is free
// ----------------------------------------------------------------------------
module blpg_walker
    import blpg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  line_cmd_t          fifo_cmd,
    input  logic               fifo_empty,
    output logic               fifo_pop,
    input  logic               pop,
    output logic               empty,
    output logic [COORD_W-1:0] pixel_col,
    output logic [COORD_W-1:0] pixel_row,
    output logic [VALUE_W-1:0] write_value,
    output logic               last_pixel
);

    // walk state
    logic                      busy_reg;
    logic                      busy_next;
    logic [COORD_W-1:0]        cur_col_reg;
    logic [COORD_W-1:0]        cur_col_next;
    logic [COORD_W-1:0]        cur_row_reg;
    logic [COORD_W-1:0]        cur_row_next;
    logic signed [ERR_W-1:0]   err_term_reg;
    logic signed [ERR_W-1:0]   err_term_next;
    logic [SPAN_W-1:0]         span_x_reg;
    logic [SPANN_W-1:0]        span_y_neg_reg;
    logic [1:0]                step_dirs_reg;
    logic [2*COORD_W-1:0]      target_point_reg;
    logic [VALUE_W-1:0]        held_value_reg;

    // output register
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [COORD_W-1:0]        pixel_col_reg;
    logic [COORD_W-1:0]        pixel_row_reg;
    logic [VALUE_W-1:0]        write_value_reg;
    logic                      last_pixel_reg;

    // step datapath
    logic                      step_fire;
    logic                      step_last;
    logic                      at_end;
    logic                      x_step;
    logic                      y_step;
    logic                      done_x;
    logic                      done_y;
    logic signed [ERR_W:0]     e2;
    logic signed [ERR_W:0]     dx_ext;
    logic signed [ERR_W:0]     dy_ext;
    logic signed [ERR_W:0]     err_sum;
    logic [COORD_W-1:0]        end_col;
    logic [COORD_W-1:0]        end_row;
    logic [ERR_W-1:0]          err_init;

    assign end_col   = target_point_reg[COORD_W-1:0];
    assign end_row   = target_point_reg[2*COORD_W-1:COORD_W];
    assign fifo_pop  = !busy_reg && !fifo_empty;
    assign step_fire = busy_reg && (!out_valid_reg || pop);

    // decisions for the current pixel
    always_comb
    begin
        e2      = $signed({err_term_reg, 1'b0});
        dx_ext  = $signed({{(ERR_W+1-SPAN_W){1'b0}}, span_x_reg});
        dy_ext  = $signed({{(ERR_W+1-SPANN_W){span_y_neg_reg[SPANN_W-1]}}, span_y_neg_reg});
        at_end  = (cur_col_reg == end_col) && (cur_row_reg == end_row);
        x_step  = (e2 >= dy_ext);
        done_x  = x_step && (cur_col_reg == end_col);
        y_step  = !done_x && (e2 <= dx_ext);
        done_y  = y_step && (cur_row_reg == end_row);
        step_last = at_end || done_x || done_y;
        err_sum = $signed({err_term_reg[ERR_W-1], err_term_reg})
                  + (x_step ? dy_ext : '0) + (y_step ? dx_ext : '0);
        err_init = ERR_W'({2'b00, fifo_cmd.span_x}) +
                   ERR_W'({fifo_cmd.span_y_neg[SPANN_W-1], fifo_cmd.span_y_neg});
    end

    // next walk position
    always_comb
    begin
        busy_next     = busy_reg;
        cur_col_next  = cur_col_reg;
        cur_row_next  = cur_row_reg;
        err_term_next = err_term_reg;
        if (fifo_pop)
        begin
            busy_next     = 1'b1;
            cur_col_next  = fifo_cmd.start_x;
            cur_row_next  = fifo_cmd.start_y;
            err_term_next = $signed(err_init);
        end
        else if (step_fire)
        begin
            if (step_last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                err_term_next = err_sum[ERR_W-1:0];
                if (x_step)
                begin
                    cur_col_next = step_dirs_reg[0] ? cur_col_reg - 1'b1 : cur_col_reg + 1'b1;
                end
                if (y_step)
                begin
                    cur_row_next = step_dirs_reg[1] ? cur_row_reg - 1'b1 : cur_row_reg + 1'b1;
                end
            end
        end
    end

    // output slot: filled by a step, freed by a pop
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
            cur_col_reg      <= '0;
            cur_row_reg      <= '0;
            err_term_reg     <= '0;
            span_x_reg       <= '0;
            span_y_neg_reg   <= '0;
            step_dirs_reg    <= '0;
            target_point_reg <= '0;
            held_value_reg   <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            err_term_reg  <= err_term_next;
            if (fifo_pop)
            begin
                span_x_reg       <= fifo_cmd.span_x;
                span_y_neg_reg   <= fifo_cmd.span_y_neg;
                step_dirs_reg    <= fifo_cmd.step_dirs;
                target_point_reg <= {fifo_cmd.end_y, fifo_cmd.end_x};
                held_value_reg   <= fifo_cmd.value;
            end
        end
    end

    // result payload, no reset
    always_ff @(posedge clk)
    begin
        if (step_fire)
        begin
            pixel_col_reg   <= cur_col_reg;
            pixel_row_reg   <= cur_row_reg;
            write_value_reg <= held_value_reg;
            last_pixel_reg  <= step_last;
        end
    end

    assign empty       = !out_valid_reg;
    assign pixel_col   = pixel_col_reg;
    assign pixel_row   = pixel_row_reg;
    assign write_value = write_value_reg;
    assign last_pixel  = last_pixel_reg;

    // a new command is only taken between lines
    `BLPG_ASSERT_IMPLY(a_pop_only_idle, fifo_pop, !busy_reg, "command taken mid line")
    // the flagged pixel ends the walk
    `BLPG_ASSERT_NEXT(a_last_ends_walk, step_fire && step_last, !busy_reg, "walk runs past end")
    // a loaded command starts at its first endpoint
    `BLPG_ASSERT_NEXT(a_load_at_start, fifo_pop,
        busy_reg && (cur_col_reg == $past(fifo_cmd.start_x))
        && (cur_row_reg == $past(fifo_cmd.start_y)), "walk not at start point")

endmodule
